// ===== rtl/core/comstr_pkg.sv =====
// shared types, character codes and helpers for the comment stripper
`default_nettype none
package comstr_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int RETRACT_WIDTH = 16;
    localparam int WIDE_WIDTH = (COUNT_WIDTH > RETRACT_WIDTH) ? COUNT_WIDTH : RETRACT_WIDTH;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic {
        KIND_EMIT    = 1'b0,
        KIND_RETRACT = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic [7:0]               out_byte;
        logic [RETRACT_WIDTH-1:0] retract_count;
    } result_t;

    // one queue entry: one or two results caused by one input byte
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    function automatic logic [RETRACT_WIDTH-1:0] clamp_count(input count_t v);
        logic [WIDE_WIDTH-1:0] w;
        w = WIDE_WIDTH'(v);
        if (w > WIDE_WIDTH'({RETRACT_WIDTH{1'b1}})) begin
            return {RETRACT_WIDTH{1'b1}};
        end
        return w[RETRACT_WIDTH-1:0];
    endfunction

    function automatic result_t make_emit(input logic [7:0] b);
        result_t r;
        r.kind = KIND_EMIT;
        r.out_byte = b;
        r.retract_count = '0;
        return r;
    endfunction

    function automatic result_t make_retract(input logic [RETRACT_WIDTH-1:0] n);
        result_t r;
        r.kind = KIND_RETRACT;
        r.out_byte = '0;
        r.retract_count = n;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/comment_stripper_top.sv =====
// Comment stripper top level: takes one source byte per transaction on the s_ channel and
// yields edit operations on the m_ channel (emit a byte, or retract a count of bytes
// already emitted), with m_last on the final operation caused by each byte; a byte may
// cause none. Bytes are accepted one per cycle while the four-entry queue between the
// scanner and the output stage has room; the output stage delivers one operation per
// cycle while m_ready is high, so a byte that causes two operations (CR LF after a line
// comment) delivers them one after the other.
`default_nettype none
module comment_stripper_top
    import comstr_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [7:0]               s_in_byte,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic                          m_kind,
    output logic [7:0]                    m_out_byte,
    output logic [RETRACT_WIDTH-1:0]      m_retract_count,
    output logic                          m_last
);

    push_t  push;
    logic   q_full;
    logic   q_not_empty;
    entry_t q_head;
    logic   q_pop;

    comstr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .q_full    (q_full),
        .push      (push)
    );

    comstr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head),
        .pop       (q_pop)
    );

    comstr_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_not_empty     (q_not_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_out_byte      (m_out_byte),
        .m_retract_count (m_retract_count),
        .m_last          (m_last)
    );

endmodule
`default_nettype wire

// ===== rtl/core/comstr_front.sv =====
// front end: scanner state, classifies each byte into queue entries
`default_nettype none
module comstr_front
    import comstr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       q_full,
    output push_t           push
);

    logic   in_quote_reg, in_quote_next;
    logic   after_bs_reg, after_bs_next;
    logic   blk_pre_reg, blk_pre_next;
    logic   ln_pre_reg, ln_pre_next;
    logic   in_blk_reg, in_blk_next;
    logic   in_ln_reg, in_ln_next;
    logic   cr_seen_reg, cr_seen_next;
    count_t char_cnt_reg, char_cnt_next;
    count_t space_cnt_reg, space_cnt_next;

    logic accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        logic   in_comment;
        logic   skip;
        logic   is_space;
        logic [7:0] c;
        c = s_in_byte;
        in_quote_next  = in_quote_reg;
        after_bs_next  = after_bs_reg;
        blk_pre_next   = blk_pre_reg;
        ln_pre_next    = ln_pre_reg;
        in_blk_next    = in_blk_reg;
        in_ln_next     = in_ln_reg;
        cr_seen_next   = cr_seen_reg;
        char_cnt_next  = char_cnt_reg;
        space_cnt_next = space_cnt_reg;
        push           = '0;
        skip           = 1'b0;
        in_comment     = in_blk_reg || in_ln_reg;
        is_space       = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);

        if (!after_bs_reg && (c == CH_QUOTE) && !in_comment) begin
            in_quote_next = !in_quote_reg;
        end
        after_bs_next = (c == CH_BACKSLASH) && !after_bs_reg;

        if (!after_bs_next && !in_quote_next) begin
            if (!in_comment) begin
                if (!blk_pre_reg && (c == CH_SLASH)) begin
                    blk_pre_next = 1'b1;
                    ln_pre_next  = 1'b1;
                end else if (blk_pre_reg && ((c == CH_STAR) || (c == CH_SLASH))) begin
                    if (c == CH_STAR) begin
                        in_blk_next = 1'b1;
                    end else begin
                        in_ln_next = 1'b1;
                    end
                    blk_pre_next = 1'b0;
                    ln_pre_next  = 1'b0;
                    // retract the slash that opened the comment
                    push.valid = 1'b1;
                    push.entry.first = make_retract(RETRACT_WIDTH'(1));
                    if (char_cnt_reg != '0) begin
                        char_cnt_next = char_cnt_reg - count_t'(1);
                    end
                end else begin
                    blk_pre_next = 1'b0;
                    ln_pre_next  = 1'b0;
                end
            end else if (in_blk_reg) begin
                if (blk_pre_reg && (c == CH_SLASH)) begin
                    blk_pre_next = 1'b0;
                    in_blk_next  = 1'b0;
                    skip         = 1'b1;
                end else begin
                    blk_pre_next = (c == CH_STAR);
                end
            end else begin
                if (ln_pre_reg && (c == CH_LF)) begin
                    ln_pre_next = 1'b0;
                    in_ln_next  = 1'b0;
                    if (space_cnt_reg != char_cnt_reg) begin
                        push.valid        = 1'b1;
                        push.entry.two    = 1'b1;
                        push.entry.first  = make_emit(CH_CR);
                        push.entry.second = make_emit(CH_LF);
                    end else if (char_cnt_reg != '0) begin
                        // line held only whitespace: drop it all
                        push.valid       = 1'b1;
                        push.entry.first = make_retract(clamp_count(char_cnt_reg));
                    end
                    char_cnt_next  = '0;
                    space_cnt_next = '0;
                    cr_seen_next   = 1'b0;
                    skip           = 1'b1;
                end else begin
                    ln_pre_next = (c == CH_CR);
                end
            end
        end

        if (!skip) begin
            if (!in_blk_next && !in_ln_next) begin
                if (char_cnt_next != '1) begin
                    char_cnt_next = char_cnt_next + count_t'(1);
                end
                if (is_space && (space_cnt_next != '1)) begin
                    space_cnt_next = space_cnt_next + count_t'(1);
                end
            end
            if (!in_blk_next) begin
                if (c == CH_CR) begin
                    cr_seen_next = 1'b1;
                end
                if (cr_seen_next && (c == CH_LF)) begin
                    char_cnt_next  = '0;
                    space_cnt_next = '0;
                    cr_seen_next   = 1'b0;
                end
            end
            if (!in_blk_next && !in_ln_next) begin
                push.valid       = 1'b1;
                push.entry.first = make_emit(c);
            end
        end

        if (!accept) begin
            push.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_quote_reg  <= 1'b0;
            after_bs_reg  <= 1'b0;
            blk_pre_reg   <= 1'b0;
            ln_pre_reg    <= 1'b0;
            in_blk_reg    <= 1'b0;
            in_ln_reg     <= 1'b0;
            cr_seen_reg   <= 1'b0;
            char_cnt_reg  <= '0;
            space_cnt_reg <= '0;
        end else if (accept) begin
            in_quote_reg  <= in_quote_next;
            after_bs_reg  <= after_bs_next;
            blk_pre_reg   <= blk_pre_next;
            ln_pre_reg    <= ln_pre_next;
            in_blk_reg    <= in_blk_next;
            in_ln_reg     <= in_ln_next;
            cr_seen_reg   <= cr_seen_next;
            char_cnt_reg  <= char_cnt_next;
            space_cnt_reg <= space_cnt_next;
        end
    end

    a_one_comment_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_blk_reg && in_ln_reg))
        else $error("block and line comment active together");

endmodule
`default_nettype wire

// ===== rtl/core/comstr_fifo.sv =====
// short entry queue between front end and back end
`default_nettype none
module comstr_fifo
    import comstr_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire push_t  push,
    output logic        full,
    output logic        not_empty,
    output entry_t      head,
    input  wire logic   pop
);

    entry_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign full      = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(do_push);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(do_pop);
        count_next  = count_reg + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push.valid)
        else $error("entry pushed into full queue");

endmodule
`default_nettype wire

// ===== rtl/core/comstr_back.sv =====
// back end: splits queue entries into single results behind an output register
`default_nettype none
module comstr_back
    import comstr_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     q_not_empty,
    input  wire entry_t                   q_head,
    output logic                          q_pop,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic                          m_kind,
    output logic [7:0]                    m_out_byte,
    output logic [RETRACT_WIDTH-1:0]      m_retract_count,
    output logic                          m_last
);

    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;
    logic    out_last_reg, out_last_next;
    result_t hold_reg, hold_next;
    logic    hold_valid_reg, hold_valid_next;
    logic    load;

    // output slot can take a new transaction
    assign load = !out_valid_reg || m_ready;

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_last_next   = out_last_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        q_pop           = 1'b0;
        if (load) begin
            if (hold_valid_reg) begin
                out_next        = hold_reg;
                out_last_next   = 1'b1;
                out_valid_next  = 1'b1;
                hold_valid_next = 1'b0;
            end else if (q_not_empty) begin
                q_pop           = 1'b1;
                out_next        = q_head.first;
                out_last_next   = !q_head.two;
                out_valid_next  = 1'b1;
                hold_next       = q_head.second;
                hold_valid_next = q_head.two;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        hold_reg     <= hold_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = out_reg.kind;
    assign m_out_byte      = out_reg.out_byte;
    assign m_retract_count = out_reg.retract_count;
    assign m_last          = out_last_reg;

    // a pending second result always follows a first one still on the port
    a_hold_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> (out_valid_reg && !out_last_reg))
        else $error("second result pending without first on output");

endmodule
`default_nettype wire

// ===== verif/tb_comment_stripper_top.sv =====
// self-checking testbench for the comment stripper: directed table, one whitespace line, random text
module tb_comment_stripper_top;
    timeunit 1ns;
    timeprecision 1ps;

    import comstr_pkg::*;

    localparam int DIR_ROWS       = 30;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int LONG_LINE      = 40;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_LIMIT    = 1000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 30;

    localparam count_t                   CNT_MAX = '1;
    localparam logic [RETRACT_WIDTH-1:0] RET_MAX = '1;

    typedef struct packed {
        kind_t                    kind;
        logic [7:0]               out_byte;
        logic [RETRACT_WIDTH-1:0] retract_count;
        logic                     last;
    } edit_t;

    // how a directed row gets its expectation
    typedef enum logic [1:0] {
        ROW_PRED,
        ROW_NONE,
        ROW_ONE
    } row_how_t;

    typedef struct packed {
        logic [7:0] b;
        row_how_t   how;
        edit_t      r;
    } row_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [7:0]               s_in_byte = 8'h00;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_kind;
    logic [7:0]               m_out_byte;
    logic [RETRACT_WIDTH-1:0] m_retract_count;
    logic                     m_last;

    comment_stripper_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_out_byte      (m_out_byte),
        .m_retract_count (m_retract_count),
        .m_last          (m_last)
    );

    always #1 aclk = ~aclk;

    // predictor state
    bit     in_str, esc_next, pfx_block, pfx_line, in_block, in_line, cr_on_line;
    count_t kept_cnt, kept_ws;

    edit_t      edit_q [$];
    logic [7:0] tok_q [$];
    row_t       dir_tab [DIR_ROWS];
    bit         quiet = 1'b0;
    int         errors = 0;
    int         bytes_fed = 0;
    int         bytes_with_output = 0;
    int         results_seen = 0;
    int         stuck_cycles = 0;

    function automatic edit_t make_edit(input kind_t k, input logic [7:0] b,
                                        input logic [31:0] cnt);
        edit_t e;
        if (cnt > 32'(RET_MAX)) begin
            cnt = 32'(RET_MAX);
        end
        e.kind = k;
        e.out_byte = b;
        e.retract_count = cnt[RETRACT_WIDTH-1:0];
        e.last = 1'b0;
        return e;
    endfunction

    function automatic void new_line();
        kept_cnt = '0;
        kept_ws = '0;
        cr_on_line = 1'b0;
    endfunction

    // one source byte in, up to two edit operations out
    function automatic int strip_step(input logic [7:0] c, output edit_t res [2]);
        int n;
        bit skip;
        bit in_cmt;
        n = 0;
        skip = 1'b0;
        in_cmt = in_block || in_line;
        res[0] = '0;
        res[1] = '0;
        if (!esc_next && c == CH_QUOTE && !in_cmt) begin
            in_str = !in_str;
        end
        esc_next = (c == CH_BACKSLASH) && !esc_next;
        if (!esc_next && !in_str) begin
            if (!in_cmt) begin
                if (!pfx_block && c == CH_SLASH) begin
                    pfx_block = 1'b1;
                    pfx_line = 1'b1;
                end else if (pfx_block && (c == CH_STAR || c == CH_SLASH)) begin
                    if (c == CH_STAR) begin
                        in_block = 1'b1;
                    end else begin
                        in_line = 1'b1;
                    end
                    pfx_block = 1'b0;
                    pfx_line = 1'b0;
                    // take back the slash that opened the comment
                    res[n] = make_edit(KIND_RETRACT, 8'h00, 32'd1);
                    n++;
                    if (kept_cnt > 0) begin
                        kept_cnt--;
                    end
                end else begin
                    pfx_block = 1'b0;
                    pfx_line = 1'b0;
                end
            end else if (in_block) begin
                if (pfx_block && c == CH_SLASH) begin
                    pfx_block = 1'b0;
                    in_block = 1'b0;
                    skip = 1'b1;
                end else begin
                    pfx_block = (c == CH_STAR);
                end
            end else begin
                if (pfx_line && c == CH_LF) begin
                    pfx_line = 1'b0;
                    in_line = 1'b0;
                    if (kept_ws != kept_cnt) begin
                        res[n] = make_edit(KIND_EMIT, CH_CR, 32'd0);
                        n++;
                        res[n] = make_edit(KIND_EMIT, CH_LF, 32'd0);
                        n++;
                    end else if (kept_cnt > 0) begin
                        // line held only whitespace: drop all of it
                        res[n] = make_edit(KIND_RETRACT, 8'h00, 32'(kept_cnt));
                        n++;
                    end
                    new_line();
                    skip = 1'b1;
                end else begin
                    pfx_line = (c == CH_CR);
                end
            end
        end
        if (!skip) begin
            if (!in_block && !in_line) begin
                if (kept_cnt < CNT_MAX) begin
                    kept_cnt++;
                end
                if ((c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) &&
                    kept_ws < CNT_MAX) begin
                    kept_ws++;
                end
            end
            if (!in_block) begin
                if (c == CH_CR) begin
                    cr_on_line = 1'b1;
                end
                if (cr_on_line && c == CH_LF) begin
                    new_line();
                end
            end
            if (!in_block && !in_line) begin
                res[n] = make_edit(KIND_EMIT, c, 32'd0);
                n++;
            end
        end
        if (n > 0) begin
            res[n-1].last = 1'b1;
        end
        return n;
    endfunction

    function automatic row_t row(input logic [7:0] b, input row_how_t how = ROW_PRED,
                                 input kind_t k = KIND_EMIT, input logic [7:0] ob = 8'h00,
                                 input logic [RETRACT_WIDTH-1:0] cnt = '0);
        row_t t;
        t.b = b;
        t.how = how;
        t.r = make_edit(k, ob, 32'(cnt));
        t.r.last = 1'b1;
        return t;
    endfunction

    function automatic logic [7:0] text_char();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] any_char();
        case ($urandom_range(0, 9))
            0: return CH_STAR;
            1: return CH_SLASH;
            2: return CH_QUOTE;
            3: return CH_BACKSLASH;
            4: return CH_CR;
            5: return CH_LF;
            6: return 8'($urandom_range(0, 255));
            default: return text_char();
        endcase
    endfunction

    // mostly well-formed pieces of source text, some noise and broken openers
    function automatic void build_token();
        int len;
        tok_q.delete();
        len = $urandom_range(0, 8);
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: begin
                repeat ($urandom_range(1, 8)) tok_q.push_back(text_char());
            end
            6, 7, 8: begin
                tok_q.push_back(CH_SLASH);
                tok_q.push_back(CH_STAR);
                repeat (len) tok_q.push_back(any_char());
                repeat ($urandom_range(1, 3)) tok_q.push_back(CH_STAR);
                tok_q.push_back(CH_SLASH);
            end
            9, 10, 11: begin
                tok_q.push_back(CH_SLASH);
                tok_q.push_back(CH_SLASH);
                repeat (len) tok_q.push_back(any_char());
                tok_q.push_back(CH_CR);
                tok_q.push_back(CH_LF);
            end
            12, 13: begin
                tok_q.push_back(CH_QUOTE);
                repeat (len) begin
                    if ($urandom_range(0, 3) == 0) begin
                        tok_q.push_back(CH_BACKSLASH);
                        tok_q.push_back(any_char());
                    end else begin
                        tok_q.push_back(text_char());
                    end
                end
                tok_q.push_back(CH_QUOTE);
            end
            14, 15: begin
                tok_q.push_back(CH_CR);
                tok_q.push_back(CH_LF);
            end
            16: begin
                tok_q.push_back(CH_CR);
                tok_q.push_back(CH_LF);
                repeat ($urandom_range(0, 3)) begin
                    tok_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                end
                tok_q.push_back(CH_SLASH);
                tok_q.push_back(CH_SLASH);
                repeat (len) tok_q.push_back(any_char());
                tok_q.push_back(CH_CR);
                tok_q.push_back(CH_LF);
            end
            17, 18: begin
                repeat ($urandom_range(1, 4)) tok_q.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                tok_q.push_back(CH_SLASH);
                tok_q.push_back(any_char());
            end
        endcase
    endfunction

    task automatic report(input string what, input logic [15:0] got,
                          input logic [15:0] want);
        errors++;
        if (errors <= PRINT_LIMIT) begin
            $display("mismatch in %s at operation %0d: got %0h, expected %0h",
                     what, results_seen, got, want);
        end
    endtask

    // one source byte over the s_ channel, then its expectations
    task automatic feed(input row_t t);
        int gap;
        int n;
        edit_t res [2];
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= t.b;
        do @(posedge aclk); while (!s_ready);
        bytes_fed++;
        n = strip_step(t.b, res);
        if (n > 0) begin
            bytes_with_output++;
        end
        if (t.how == ROW_PRED) begin
            for (int i = 0; i < n; i++) edit_q.push_back(res[i]);
        end else if (t.how == ROW_ONE) begin
            edit_q.push_back(t.r);
        end
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (edit_q.size() != 0);
    endtask

    initial begin : source_side
        int waited;
        in_str = 1'b0;
        esc_next = 1'b0;
        pfx_block = 1'b0;
        pfx_line = 1'b0;
        in_block = 1'b0;
        in_line = 1'b0;
        new_line();
        dir_tab = '{
            row(8'h00, ROW_ONE, KIND_EMIT, 8'h00),
            row(8'hFF, ROW_ONE, KIND_EMIT, 8'hFF),
            row(CH_LF),
            row(CH_SLASH, ROW_ONE, KIND_EMIT, CH_SLASH),
            row(CH_STAR, ROW_ONE, KIND_RETRACT, 8'h00, 16'd1),
            row(CH_QUOTE, ROW_NONE),
            row(CH_STAR, ROW_NONE),
            row(CH_SLASH, ROW_NONE),
            row(CH_QUOTE),
            row(CH_SLASH),
            row(CH_BACKSLASH),
            row(CH_QUOTE),
            row(CH_QUOTE),
            row(CH_CR),
            row(CH_LF),
            row(CH_TAB),
            row(CH_SLASH),
            row(CH_SLASH),
            row(CH_CR),
            row(CH_CR),
            row(CH_LF),
            row(CH_SLASH),
            row(CH_SLASH),
            row(CH_CR),
            row(CH_LF),
            row(8'h71),
            row(CH_SLASH),
            row(CH_SLASH),
            row(CH_CR),
            row(CH_LF)
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) feed(dir_tab[i]);
        pause_until_drained();

        // a long whitespace line ended by a line comment
        quiet = 1'b1;
        feed(row(CH_CR));
        feed(row(CH_LF));
        repeat (LONG_LINE) feed(row($urandom_range(0, 1) ? CH_SPACE : CH_TAB));
        feed(row(CH_SLASH));
        feed(row(CH_SLASH));
        feed(row(8'h7A));
        feed(row(CH_CR));
        feed(row(CH_LF));
        quiet = 1'b0;

        while (bytes_fed < RANDOM_ITEMS) begin
            if ($urandom_range(0, 15) == 0) begin
                quiet = !quiet;
            end
            if ($urandom_range(0, 49) == 0) begin
                pause_until_drained();
            end
            build_token();
            foreach (tok_q[i]) feed(row(tok_q[i]));
        end
        s_valid <= 1'b0;

        waited = 0;
        while (edit_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (edit_q.size() != 0) begin
            report("left-over expectations", 16'(edit_q.size()), 16'd0);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("fed %0d source bytes, %0d of them produced output (one %0d byte blank line)",
                 bytes_fed, bytes_with_output, LONG_LINE);
        $display("checked %0d edit operations, %0d mismatches", results_seen, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : sink_side
        int stall;
        edit_t want;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_seen++;
            if (edit_q.size() == 0) begin
                report("unexpected transaction", {15'd0, m_kind}, 16'd0);
            end else begin
                want = edit_q.pop_front();
                if (m_kind !== want.kind) begin
                    report("kind", {15'd0, m_kind}, {15'd0, want.kind});
                end
                if (m_out_byte !== want.out_byte) begin
                    report("out_byte", {8'd0, m_out_byte}, {8'd0, want.out_byte});
                end
                if (m_retract_count !== want.retract_count) begin
                    report("retract_count", 16'(m_retract_count), 16'(want.retract_count));
                end
                if (m_last !== want.last) begin
                    report("last", {15'd0, m_last}, {15'd0, want.last});
                end
            end
        end
    end

    // ends the run when neither channel has moved for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule

// ===== comment_stripper_top.f =====
rtl/core/comstr_pkg.sv
rtl/core/comstr_front.sv
rtl/core/comstr_fifo.sv
rtl/core/comstr_back.sv
rtl/core/comment_stripper_top.sv
verif/tb_comment_stripper_top.sv
